@@ hdl/pkfu_pkg.sv @@
// Shared types and constants for the particle kinematic and flipbook update block.
// Depends on nothing; imported by every module of the block.
package pkfu_pkg;

  localparam int DT_W    = 21;
  localparam int LIFE_W  = 31;
  localparam int COORD_W = 32;
  localparam int TEX_W   = 4;

  localparam logic [DT_W-1:0] DT_RESET = 21'd1092;

  typedef struct packed {
    logic [LIFE_W-1:0]         life_in;
    logic [LIFE_W-1:0]         start_life;
    logic signed [COORD_W-1:0] pos_x_in;
    logic signed [COORD_W-1:0] pos_y_in;
    logic signed [COORD_W-1:0] pos_z_in;
    logic signed [COORD_W-1:0] vel_x_in;
    logic signed [COORD_W-1:0] vel_y_in;
    logic signed [COORD_W-1:0] vel_z_in;
    logic signed [COORD_W-1:0] acc_x;
    logic signed [COORD_W-1:0] acc_y;
    logic signed [COORD_W-1:0] acc_z;
    logic [TEX_W-1:0]          texture_index;
  } particle_t;

  typedef struct packed {
    logic [LIFE_W-1:0]         life_out;
    logic signed [COORD_W-1:0] pos_x_out;
    logic signed [COORD_W-1:0] pos_y_out;
    logic signed [COORD_W-1:0] pos_z_out;
    logic signed [COORD_W-1:0] vel_x_out;
    logic signed [COORD_W-1:0] vel_y_out;
    logic signed [COORD_W-1:0] vel_z_out;
    logic [3:0]                cell_col;
    logic [4:0]                cell_row;
    logic [3:0]                next_col;
    logic [4:0]                next_row;
    logic [15:0]               blend_frac;
  } update_t;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] x);
    logic signed [COORD_W-1:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = COORD_W'(x);
    end
    return r;
  endfunction

endpackage

@@ hdl/pkfu_axis.sv @@
// One axis of the kinematic update: velocity += a*dt, position += v*dt + a*dt*dt/2.
// Four compute stages, then delay registers to the common pipeline depth. Uses pkfu_pkg.
module pkfu_axis import pkfu_pkg::*; #(
  parameter int DEPTH = 13
) (
  input  logic                      clk,
  input  logic [DEPTH-1:0]          adv,
  input  logic [DT_W-1:0]           dt,
  input  logic signed [COORD_W-1:0] pos,
  input  logic signed [COORD_W-1:0] vel,
  input  logic signed [COORD_W-1:0] acc,
  output logic signed [COORD_W-1:0] pos_new,
  output logic signed [COORD_W-1:0] vel_new
);

  localparam int PW  = COORD_W + DT_W + 1;
  localparam int ADW = PW - 16;
  localparam int QW  = ADW + DT_W + 1;
  localparam int SW  = QW + 1;
  localparam int DW  = SW - 17;

  logic signed [DT_W:0]    dts;
  logic signed [PW-1:0]    s0_adt;
  logic signed [PW-1:0]    s0_vdt;
  logic signed [COORD_W-1:0] s0_pos;
  logic signed [COORD_W-1:0] s0_vel;
  logic signed [ADW-1:0]   ad;
  logic signed [QW-1:0]    s1_addt;
  logic signed [PW-1:0]    s1_vdt;
  logic signed [COORD_W-1:0] s1_pos;
  logic signed [SW-1:0]    dsum;
  logic signed [DW-1:0]    s2_dp;
  logic signed [COORD_W-1:0] s2_pos;
  logic signed [COORD_W-1:0] vel_q [1:DEPTH-1];
  logic signed [COORD_W-1:0] pos_q [3:DEPTH-1];

  assign dts  = signed'({1'b0, dt});
  assign ad   = ADW'(s0_adt >>> 16);
  assign dsum = (SW'(s1_vdt) <<< 1) + SW'(s1_addt);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_adt <= acc * dts;
      s0_vdt <= vel * dts;
      s0_pos <= pos;
      s0_vel <= vel;
    end
    if (adv[1]) begin
      vel_q[1] <= sat32(64'(s0_vel) + 64'(ad));
      s1_addt  <= ad * dts;
      s1_vdt   <= s0_vdt;
      s1_pos   <= s0_pos;
    end
    if (adv[2]) begin
      s2_dp  <= DW'(dsum >>> 17);
      s2_pos <= s1_pos;
    end
    if (adv[3]) begin
      pos_q[3] <= sat32(64'(s2_pos) + 64'(s2_dp));
    end
    for (int i = 2; i < DEPTH; i++) begin
      if (adv[i]) begin
        vel_q[i] <= vel_q[i-1];
      end
    end
    for (int i = 4; i < DEPTH; i++) begin
      if (adv[i]) begin
        pos_q[i] <= pos_q[i-1];
      end
    end
  end

  assign pos_new = pos_q[DEPTH-1];
  assign vel_new = vel_q[DEPTH-1];

endmodule

@@ hdl/pkfu_frame.sv @@
// Life decrement, life fraction by pipelined restoring division, and flipbook cell lookup.
// Stage 0 ages the particle, stage 1 sets up the division, then STEPS quotient bits per
// stage, last stage picks the cells. Uses pkfu_pkg.
module pkfu_frame import pkfu_pkg::*; #(
  parameter int INNER_GRID = 4,
  parameter int OUTER_GRID = 4,
  parameter int STEPS      = 2,
  parameter int DEPTH      = 13
) (
  input  logic              clk,
  input  logic [DEPTH-1:0]  adv,
  input  logic [DEPTH-1:0]  valid,
  input  logic [DT_W-1:0]   dt,
  input  logic [LIFE_W-1:0] life_in,
  input  logic [LIFE_W-1:0] start_life,
  input  logic [TEX_W-1:0]  texture_index,
  output logic [LIFE_W-1:0] life_out,
  output logic [3:0]        cell_col,
  output logic [4:0]        cell_row,
  output logic [3:0]        next_col,
  output logic [4:0]        next_row,
  output logic [15:0]       blend_frac
);

  localparam int N   = INNER_GRID * INNER_GRID;
  localparam int QI  = $clog2(N);
  localparam int Q   = 16 + QI;
  localparam int NDW = LIFE_W + QI;
  localparam int FW  = $clog2(N + 2);
  localparam int SW  = 16 + FW;
  localparam int BW  = 8;
  localparam int TSH = 2 * TEX_W;
  localparam int TM  = ((1 << TSH) + OUTER_GRID - 1) / OUTER_GRID;
  localparam int FSH = FW + 4;
  localparam int FM  = ((1 << FSH) + INNER_GRID - 1) / INNER_GRID;
  localparam int FPW = FW + FSH + 1;

  typedef struct packed {
    logic [LIFE_W-1:0] life_out;
    logic [LIFE_W-1:0] start;
    logic [BW-1:0]     base_col;
    logic [BW-1:0]     base_row;
  } age_t;

  typedef struct packed {
    logic [LIFE_W-1:0] life_out;
    logic [LIFE_W-1:0] start;
    logic [LIFE_W-1:0] rem;
    logic [Q-1:0]      pend;
    logic [Q-1:0]      quo;
    logic              zero;
    logic              clamp;
    logic [BW-1:0]     base_col;
    logic [BW-1:0]     base_row;
  } div_t;

  // exact x / INNER_GRID by reciprocal multiply for x < 2**FW
  function automatic logic [FW-1:0] fdiv(input logic [FW-1:0] x);
    logic [FPW-1:0] p;
    p = FPW'(x) * FPW'(FM);
    return FW'(p >> FSH);
  endfunction

  age_t                 s0;
  div_t                 dv      [1:DEPTH-2];
  div_t                 dv_next [1:DEPTH-2];
  logic [LIFE_W-1:0]    life_dec;
  logic [TSH+TEX_W:0]   t_prod;
  logic [TEX_W-1:0]     t_q;
  logic [TEX_W-1:0]     t_r;
  logic [BW-1:0]        t_back;
  logic [SW-1:0]        s;
  logic [FW-1:0]        frame;
  logic [FW-1:0]        nxt;
  logic [FW-1:0]        f_q;
  logic [FW-1:0]        f_r;
  logic [FW-1:0]        n_q;
  logic [FW-1:0]        n_r;
  div_t                 fin;

  assign life_dec = (life_in > LIFE_W'(dt)) ? life_in - LIFE_W'(dt) : '0;
  assign t_prod   = (TSH+TEX_W+1)'(texture_index) * (TSH+TEX_W+1)'(TM);
  assign t_q      = TEX_W'(t_prod >> TSH);
  assign t_back   = BW'(t_q) * BW'(OUTER_GRID);
  assign t_r      = TEX_W'(BW'(texture_index) - t_back);

  always_comb begin
    div_t                 cur;
    logic [LIFE_W-1:0]    d;
    logic [NDW-1:0]       nd;
    logic [NDW+15:0]      ext;
    logic [LIFE_W:0]      t;
    logic                 qb;
    d   = s0.start - s0.life_out;
    nd  = NDW'(d) * NDW'(N);
    ext = {nd, 16'b0};
    cur.life_out = s0.life_out;
    cur.start    = s0.start;
    cur.rem      = ext[NDW+15:Q];
    cur.pend     = ext[Q-1:0];
    cur.quo      = '0;
    // zero start or no life left: full fraction
    cur.zero     = (s0.start == '0) || (s0.life_out == '0);
    cur.clamp    = (s0.life_out >= s0.start);
    cur.base_col = s0.base_col;
    cur.base_row = s0.base_row;
    dv_next[1]   = cur;
    for (int i = 2; i <= DEPTH - 2; i++) begin
      cur = dv[i-1];
      for (int k = 0; k < STEPS; k++) begin
        if ((i - 2) * STEPS + k < Q) begin
          t = {cur.rem, cur.pend[Q-1]};
          qb = (t >= {1'b0, cur.start});
          if (qb) begin
            cur.rem = LIFE_W'(t - {1'b0, cur.start});
          end else begin
            cur.rem = t[LIFE_W-1:0];
          end
          cur.pend = cur.pend << 1;
          cur.quo  = {cur.quo[Q-2:0], qb};
        end
      end
      dv_next[i] = cur;
    end
  end

  assign fin   = dv[DEPTH-2];
  assign s     = fin.zero ? (SW'(N) << 16) : (fin.clamp ? '0 : SW'(fin.quo));
  assign frame = FW'(s >> 16);
  assign nxt   = frame + FW'(1);
  assign f_q   = fdiv(frame);
  assign f_r   = frame - FW'(f_q * FW'(INNER_GRID));
  assign n_q   = fdiv(nxt);
  assign n_r   = nxt - FW'(n_q * FW'(INNER_GRID));

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0.life_out <= life_dec;
      s0.start    <= start_life;
      s0.base_col <= BW'(t_r) * BW'(INNER_GRID);
      s0.base_row <= BW'(t_q) * BW'(INNER_GRID);
    end
    for (int i = 1; i <= DEPTH - 2; i++) begin
      if (adv[i]) begin
        dv[i] <= dv_next[i];
      end
    end
    if (adv[DEPTH-1]) begin
      life_out   <= fin.life_out;
      cell_col   <= 4'((BW+1)'(fin.base_col) + (BW+1)'(f_r));
      cell_row   <= 5'((BW+1)'(fin.base_row) + (BW+1)'(f_q));
      next_col   <= 4'((BW+1)'(fin.base_col) + (BW+1)'(n_r));
      next_row   <= 5'((BW+1)'(fin.base_row) + (BW+1)'(n_q));
      blend_frac <= s[15:0];
    end
  end

  a_div_setup: assert property (@(posedge clk)
    valid[1] && !dv[1].zero && !dv[1].clamp |-> dv[1].rem < dv[1].start)
    else $error("division setup remainder not below divisor");

  a_div_rem: assert property (@(posedge clk)
    valid[DEPTH-2] && !fin.zero && !fin.clamp |-> fin.rem < fin.start)
    else $error("final division remainder not below divisor");

  a_div_frame: assert property (@(posedge clk)
    valid[DEPTH-2] && !fin.zero && !fin.clamp |-> (fin.quo >> 16) < Q'(N))
    else $error("frame index past last frame");

endmodule

@@ hdl/particle_kinematic_flipbook_update_top.sv @@
// Top level of the particle kinematic and flipbook update block.
// Holds the time-step register and the pipeline handshake; instances pkfu_axis (x3) and
// pkfu_frame. Uses pkfu_pkg.
//
//   port             dir  width      transfer rule
//   particle*        in   particle_t particle_valid & particle_ready
//   update*          out  update_t   update_valid & update_ready
//   dt_we / dt_data  in   1 / 21     write on any edge with dt_we high and rst low
//
// One particle per cycle while the output is not stalled; the pipeline depth DEPTH is set
// by the fraction divider that retires STEPS quotient bits per stage.
// rst (synchronous) empties the pipeline and loads the time step with 1092.
// Every stage holds on a stall; a stage that is empty takes new data, so bubbles close
// up and input is still taken while a finished result waits.
module particle_kinematic_flipbook_update_top import pkfu_pkg::*; #(
  parameter int INNER_GRID = 4,
  parameter int OUTER_GRID = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            particle_valid,
  output logic            particle_ready,
  input  particle_t       particle,
  output logic            update_valid,
  input  logic            update_ready,
  output update_t         update,
  input  logic            dt_we,
  input  logic [DT_W-1:0] dt_data
);

  localparam int STEPS      = 2;
  localparam int QBITS      = 16 + $clog2(INNER_GRID * INNER_GRID);
  localparam int DIV_STAGES = (QBITS + STEPS - 1) / STEPS;
  localparam int DEPTH      = DIV_STAGES + 3;

  logic [DT_W-1:0]  delta_time;
  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] adv;

  always_comb begin
    adv[DEPTH-1] = !valid[DEPTH-1] || update_ready;
    for (int i = DEPTH - 2; i >= 0; i--) begin
      adv[i] = !valid[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      delta_time <= DT_RESET;
    end else begin
      if (dt_we) begin
        delta_time <= dt_data;
      end
      if (adv[0]) begin
        valid[0] <= particle_valid;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (adv[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign particle_ready = adv[0];
  assign update_valid   = valid[DEPTH-1];

  pkfu_axis #(.DEPTH(DEPTH)) u_axis_x (
    .clk     (clk),
    .adv     (adv),
    .dt      (delta_time),
    .pos     (particle.pos_x_in),
    .vel     (particle.vel_x_in),
    .acc     (particle.acc_x),
    .pos_new (update.pos_x_out),
    .vel_new (update.vel_x_out)
  );

  pkfu_axis #(.DEPTH(DEPTH)) u_axis_y (
    .clk     (clk),
    .adv     (adv),
    .dt      (delta_time),
    .pos     (particle.pos_y_in),
    .vel     (particle.vel_y_in),
    .acc     (particle.acc_y),
    .pos_new (update.pos_y_out),
    .vel_new (update.vel_y_out)
  );

  pkfu_axis #(.DEPTH(DEPTH)) u_axis_z (
    .clk     (clk),
    .adv     (adv),
    .dt      (delta_time),
    .pos     (particle.pos_z_in),
    .vel     (particle.vel_z_in),
    .acc     (particle.acc_z),
    .pos_new (update.pos_z_out),
    .vel_new (update.vel_z_out)
  );

  pkfu_frame #(
    .INNER_GRID (INNER_GRID),
    .OUTER_GRID (OUTER_GRID),
    .STEPS      (STEPS),
    .DEPTH      (DEPTH)
  ) u_frame (
    .clk           (clk),
    .adv           (adv),
    .valid         (valid),
    .dt            (delta_time),
    .life_in       (particle.life_in),
    .start_life    (particle.start_life),
    .texture_index (particle.texture_index),
    .life_out      (update.life_out),
    .cell_col      (update.cell_col),
    .cell_row      (update.cell_row),
    .next_col      (update.next_col),
    .next_row      (update.next_row),
    .blend_frac    (update.blend_frac)
  );

  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !particle_ready |-> &valid)
    else $error("input blocked while pipeline has a bubble");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !update_valid |-> particle_ready)
    else $error("input blocked with empty output stage");

  a_item_count: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> $countones(valid) == $past($countones(valid))
      + int'($past(particle_valid && particle_ready))
      - int'($past(update_valid && update_ready)))
    else $error("items lost or duplicated in pipeline");

endmodule

@@ verif/pkfu_update_checker.sv @@
`timescale 1ns / 1ps
// Checker for the particle kinematic and flipbook update block: predicts each update from
// the accepted particle and the current time step and compares it field by field.
// Depends on pkfu_pkg for the payload types and the time-step reset value.
module pkfu_update_checker import pkfu_pkg::*; #(
  parameter int INNER_GRID = 4,
  parameter int OUTER_GRID = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            particle_valid,
  input  logic            particle_ready,
  input  particle_t       particle,
  input  logic            update_valid,
  input  logic            update_ready,
  input  update_t         update,
  input  logic            dt_we,
  input  logic [DT_W-1:0] dt_data,
  output int              errors,
  output int              checked,
  output int              pending
);

  logic [DT_W-1:0] time_step;
  update_t         expected_updates[$];

  function automatic logic signed [COORD_W-1:0] clamp32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return COORD_W'(x);
  endfunction

  // constant-acceleration step; >>> on signed 64-bit floors toward minus infinity
  function automatic void advance_axis(input logic signed [COORD_W-1:0] p, v, a,
                                       input logic [DT_W-1:0] dt,
                                       output logic signed [COORD_W-1:0] p_new, v_new);
    longint sdt, ad, dp;
    sdt = longint'(dt);
    ad = (longint'(a) * sdt) >>> 16;
    dp = (2 * longint'(v) * sdt + ad * sdt) >>> 17;
    v_new = clamp32(longint'(v) + ad);
    p_new = clamp32(longint'(p) + dp);
  endfunction

  function automatic update_t predict_update(input particle_t p, input logic [DT_W-1:0] dt);
    update_t          u;
    longint unsigned  life_left, start, frac, frame, nxt, base_col, base_row;
    longint unsigned  frames;
    frames = INNER_GRID * INNER_GRID;
    life_left = (64'(p.life_in) > 64'(dt)) ? 64'(p.life_in) - 64'(dt) : 64'd0;
    start = 64'(p.start_life);
    u.life_out = LIFE_W'(life_left);
    advance_axis(p.pos_x_in, p.vel_x_in, p.acc_x, dt, u.pos_x_out, u.vel_x_out);
    advance_axis(p.pos_y_in, p.vel_y_in, p.acc_y, dt, u.pos_y_out, u.vel_y_out);
    advance_axis(p.pos_z_in, p.vel_z_in, p.acc_z, dt, u.pos_z_out, u.vel_z_out);
    if (start == 0) frac = frames << 16;
    else if (life_left >= start) frac = 0;
    else frac = ((frames * (start - life_left)) << 16) / start;
    frame = frac >> 16;
    nxt = frame + 1;
    base_col = (64'(p.texture_index) % OUTER_GRID) * INNER_GRID;
    base_row = (64'(p.texture_index) / OUTER_GRID) * INNER_GRID;
    u.cell_col = 4'(base_col + frame % INNER_GRID);
    u.cell_row = 5'(base_row + frame / INNER_GRID);
    u.next_col = 4'(base_col + nxt % INNER_GRID);
    u.next_row = 5'(base_row + nxt / INNER_GRID);
    u.blend_frac = 16'(frac);
    return u;
  endfunction

  task automatic check_field(input string fname, input longint want, input longint got);
    if (want != got) begin
      errors++;
      if (errors <= 10)
        $display("mismatch on update %0d, %s: expected %0d, got %0d", checked, fname, want, got);
    end
  endtask

  task automatic compare_update(input update_t want, input update_t got);
    check_field("life_out", want.life_out, got.life_out);
    check_field("pos_x_out", want.pos_x_out, got.pos_x_out);
    check_field("pos_y_out", want.pos_y_out, got.pos_y_out);
    check_field("pos_z_out", want.pos_z_out, got.pos_z_out);
    check_field("vel_x_out", want.vel_x_out, got.vel_x_out);
    check_field("vel_y_out", want.vel_y_out, got.vel_y_out);
    check_field("vel_z_out", want.vel_z_out, got.vel_z_out);
    check_field("cell_col", want.cell_col, got.cell_col);
    check_field("cell_row", want.cell_row, got.cell_row);
    check_field("next_col", want.next_col, got.next_col);
    check_field("next_row", want.next_row, got.next_row);
    check_field("blend_frac", want.blend_frac, got.blend_frac);
  endtask

  always @(posedge clk) begin
    update_t want;
    if (rst) begin
      time_step = DT_RESET;
      expected_updates.delete();
    end else begin
      if (particle_valid && particle_ready)
        expected_updates.push_back(predict_update(particle, time_step));
      if (update_valid && update_ready) begin
        if (expected_updates.size() == 0) begin
          errors++;
          if (errors <= 10) $display("update transfer with nothing expected: %h", update);
        end else begin
          want = expected_updates.pop_front();
          compare_update(want, update);
          checked++;
        end
      end
      if (dt_we) time_step = dt_data;
    end
    pending <= expected_updates.size();
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Top of the particle kinematic and flipbook update testbench: clock, reset, particle
// stimulus, time-step writes and random output stalls. Depends on pkfu_pkg, the block
// and pkfu_update_checker.
module testbench;
  import pkfu_pkg::*;

  localparam int INNER_GRID = 4;
  localparam int OUTER_GRID = 4;
  localparam int PHASES = 9;
  localparam int PARTICLES_PER_PHASE = 217;
  localparam int DRAIN_CYCLES = 30;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [DT_W-1:0] DT_MAX = 21'd1048576;
  localparam logic [LIFE_W-1:0] LIFE_MAX = {LIFE_W{1'b1}};
  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            particle_valid = 1'b0;
  logic            particle_ready;
  particle_t       particle = '0;
  logic            update_valid;
  logic            update_ready = 1'b0;
  update_t         update;
  logic            dt_we = 1'b0;
  logic [DT_W-1:0] dt_data = '0;

  int errors, checked, pending;
  int sent = 0;
  int cycles = 0;
  int stall_left = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always #5 clk = ~clk;

  particle_kinematic_flipbook_update_top #(
    .INNER_GRID(INNER_GRID),
    .OUTER_GRID(OUTER_GRID)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .particle_valid(particle_valid),
    .particle_ready(particle_ready),
    .particle(particle),
    .update_valid(update_valid),
    .update_ready(update_ready),
    .update(update),
    .dt_we(dt_we),
    .dt_data(dt_data)
  );

  pkfu_update_checker #(
    .INNER_GRID(INNER_GRID),
    .OUTER_GRID(OUTER_GRID)
  ) i_checker (
    .clk(clk),
    .rst(rst),
    .particle_valid(particle_valid),
    .particle_ready(particle_ready),
    .particle(particle),
    .update_valid(update_valid),
    .update_ready(update_ready),
    .update(update),
    .dt_we(dt_we),
    .dt_data(dt_data),
    .errors(errors),
    .checked(checked),
    .pending(pending)
  );

  function automatic int pick_gap();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic logic signed [COORD_W-1:0] random_coord();
    case ($urandom_range(0, 9))
      0: return C_MAX;
      1: return C_MIN;
      2, 3, 4: return $urandom();
      default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  function automatic logic [LIFE_W-1:0] random_life();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return LIFE_MAX;
      2, 3: return LIFE_W'($urandom());
      default: return LIFE_W'($urandom_range(0, 32'h0040_0000));
    endcase
  endfunction

  function automatic particle_t uniform_particle(input logic [LIFE_W-1:0] life, start,
                                                 input logic signed [COORD_W-1:0] pos, vel, acc,
                                                 input logic [TEX_W-1:0] tex);
    particle_t p;
    p.life_in = life;
    p.start_life = start;
    p.pos_x_in = pos;
    p.pos_y_in = pos;
    p.pos_z_in = pos;
    p.vel_x_in = vel;
    p.vel_y_in = vel;
    p.vel_z_in = vel;
    p.acc_x = acc;
    p.acc_y = acc;
    p.acc_z = acc;
    p.texture_index = tex;
    return p;
  endfunction

  // mostly life within start life so every frame shows up; some zero start, some overage
  function automatic particle_t random_particle();
    particle_t p;
    p.start_life = random_life();
    case ($urandom_range(0, 9))
      0: p.start_life = '0;
      1: p.life_in = p.start_life + LIFE_W'($urandom_range(1, 32'h0020_0000));
      2: p.life_in = random_life();
      default: p.life_in = LIFE_W'($urandom_range(0, p.start_life));
    endcase
    if (p.start_life == '0) p.life_in = random_life();
    p.pos_x_in = random_coord();
    p.pos_y_in = random_coord();
    p.pos_z_in = random_coord();
    p.vel_x_in = random_coord();
    p.vel_y_in = random_coord();
    p.vel_z_in = random_coord();
    p.acc_x = random_coord();
    p.acc_y = random_coord();
    p.acc_z = random_coord();
    p.texture_index = TEX_W'($urandom_range(0, 15));
    return p;
  endfunction

  task automatic send_particle(input particle_t p);
    particle <= p;
    particle_valid <= 1'b1;
    do @(posedge clk); while (!particle_ready);
    sent++;
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      particle_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task automatic wait_quiet();
    particle_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_time_step(input logic [DT_W-1:0] value);
    dt_we <= 1'b1;
    dt_data <= value;
    @(posedge clk);
    dt_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      update_ready <= 1'b0;
    end else if (recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct) begin
      stall_left = pick_gap() - 1;
      update_ready <= 1'b0;
    end else begin
      update_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[particle_kinematic_flipbook_update_top] ERROR");
      $finish;
    end
  end

  initial begin
    particle_t       p;
    logic [DT_W-1:0] phase_dt [PHASES];
    int              idle_levels [3];
    idle_levels = '{0, 15, 50};
    phase_dt = '{21'd0, DT_MAX, 21'd1, 21'd65536, 21'd0, 21'd0, 21'd0, 21'd3, DT_RESET};
    for (int i = 4; i < 7; i++) phase_dt[i] = DT_W'($urandom_range(0, DT_MAX));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed set at the reset time step, no idling
    send_particle(uniform_particle('0, '0, '0, '0, '0, 4'd0));
    send_particle(uniform_particle(LIFE_MAX, LIFE_MAX, C_MAX, C_MAX, C_MAX, 4'd15));
    send_particle(uniform_particle(LIFE_MAX, '0, C_MIN, C_MIN, C_MIN, 4'd0));
    send_particle(uniform_particle(31'd1092, 31'd5000, -32'sd1, -32'sd1, -32'sd1, 4'd5));
    send_particle(uniform_particle(31'd1000, 31'd70000, 32'sd1, -32'sd3, 32'sd7, 4'd6));
    send_particle(uniform_particle(31'd100000, 31'd50000, -32'sd5, 32'sd9, -32'sd65536, 4'd9));
    send_particle(uniform_particle(31'd51092, 31'd50000, 32'sd65536, -32'sd1, 32'sd1, 4'd3));
    // last frame in tile 15: next cell falls one row past the tile
    send_particle(uniform_particle(31'd1093, 31'd1048576, 32'sd100, 32'sd200, -32'sd300, 4'd15));
    p = uniform_particle(31'd40000, 31'd80000, 32'sd0, 32'sd0, 32'sd0, 4'd10);
    p.pos_x_in = C_MAX;
    p.vel_x_in = C_MAX;
    p.acc_y = C_MIN;
    p.vel_z_in = C_MIN;
    p.pos_z_in = C_MIN;
    send_particle(p);
    for (int t = 0; t < 16; t++)
      send_particle(uniform_particle(LIFE_W'(1092 + t * 4096), 31'd65536,
                                     -32'sd12345, 32'sd54321, -32'sd777, TEX_W'(t)));

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_quiet();
      load_time_step(phase_dt[ph]);
      send_idle_pct = idle_levels[ph % 3];
      recv_stall_pct = idle_levels[(ph / 3) % 3];
      repeat (PARTICLES_PER_PHASE) send_particle(random_particle());
    end
    wait_quiet();

    $display("Sent %0d particles over %0d time-step settings, zero and full scale included;",
             sent, PHASES + 1);
    $display("%0d updates compared, %0d field mismatches.", checked, errors);
    if (errors == 0) begin
      $display("[particle_kinematic_flipbook_update_top] OK");
    end else begin
      $display("[particle_kinematic_flipbook_update_top] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/pkfu_pkg.sv
hdl/pkfu_axis.sv
hdl/pkfu_frame.sv
hdl/particle_kinematic_flipbook_update_top.sv
verif/pkfu_update_checker.sv
verif/testbench.sv
